// ----- hw/rtl/qsfm_pkg.sv -----
// Shared types, constants and microcode ROM for the quadrotor mixer.
package qsfm_pkg;

  // Payload widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned EXTRA_W = 17;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned TERM_W  = 3;
  localparam int unsigned NTERMS  = 8;
  localparam int unsigned NMOTORS = 4;

  // Datapath widths
  localparam int unsigned CONST_W = 26;  // folded gains, positive, < 2^25
  localparam int unsigned P1_W    = 33;  // state * Q8.8 gain
  localparam int unsigned P2_W    = 59;  // P1 * folded constant
  localparam int unsigned ACC_W   = 61;  // sum of up to five products
  localparam int unsigned SUM_W   = 20;  // drive + thrust + extra thrust

  localparam logic [FIELD_W-1:0] DRIVE_MAX = 16'd65500;
  localparam logic [16:0]        DRIVE_PRECLAMP = 17'd131071;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_REF_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ANGLE_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RATE_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_YAW_RATE_GAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_EXTRA_THRUST  = 3'd4;

  localparam logic [FIELD_W-1:0] RST_REF_GAIN      = 16'd7680;
  localparam logic [FIELD_W-1:0] RST_ANGLE_GAIN    = 16'd2560;
  localparam logic [FIELD_W-1:0] RST_RATE_GAIN     = 16'd307;
  localparam logic [FIELD_W-1:0] RST_YAW_RATE_GAIN = 16'd256;

  // Terms, in microcode order
  localparam logic [TERM_W-1:0] T_ROLL      = 3'd0;
  localparam logic [TERM_W-1:0] T_PITCH     = 3'd1;
  localparam logic [TERM_W-1:0] T_ROLL_RATE = 3'd2;
  localparam logic [TERM_W-1:0] T_PITCH_RT  = 3'd3;
  localparam logic [TERM_W-1:0] T_YAW_RATE  = 3'd4;
  localparam logic [TERM_W-1:0] T_REF_ROLL  = 3'd5;
  localparam logic [TERM_W-1:0] T_REF_PITCH = 3'd6;
  localparam logic [TERM_W-1:0] T_REF_YAW   = 3'd7;

  // Folded gains per term: thrust conversion * gain * 4096
  localparam logic [CONST_W-1:0] TERM_CONST [NTERMS] = '{
    26'd6173195, 26'd6353793, 26'd19573989, 26'd20157742,
    26'd31686876, 26'd108249, 26'd111433, 26'd553979
  };

  // Subtract mask per term, bit k for motor k. Pitch reference negation folded in.
  localparam logic [NMOTORS-1:0] TERM_SUB [NTERMS] = '{
    4'b1100, 4'b0110, 4'b1100, 4'b0110,
    4'b1010, 4'b0011, 4'b0110, 4'b0101
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_rate;
    logic signed [FIELD_W-1:0] pitch_rate;
    logic signed [FIELD_W-1:0] yaw_rate;
    logic signed [FIELD_W-1:0] ref_roll;
    logic signed [FIELD_W-1:0] ref_pitch;
    logic signed [FIELD_W-1:0] ref_yaw_rate;
    logic        [FIELD_W-1:0] thrust_cmd;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] motor_one;
    logic [FIELD_W-1:0] motor_two;
    logic [FIELD_W-1:0] motor_three;
    logic [FIELD_W-1:0] motor_four;
    logic               cutoff_active;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_WAIT_IN,
    OP_NEXT,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              m1_en;
    logic [TERM_W-1:0] m1_term;
    logic              m2_en;
    logic [TERM_W-1:0] m2_term;
    logic              acc_en;
    logic [TERM_W-1:0] acc_term;
    logic              fin_en;
    logic [1:0]        fin_motor;
    logic              trip_en;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   load;
    logic   publish;
  } dp_ctrl_t;

  // Microcode ROM: wait for a request, multiply by gain, multiply by folded constant,
  // accumulate, three-deep across the eight terms; finish one motor a step, then publish.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      4'd0:  w = '{OP_WAIT_IN, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 2'd0, 1'b0};
      4'd1:  w = '{OP_NEXT,    1'b1, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 2'd0, 1'b0};
      4'd2:  w = '{OP_NEXT,    1'b1, 3'd1, 1'b1, 3'd0, 1'b0, 3'd0, 1'b0, 2'd0, 1'b0};
      4'd3:  w = '{OP_NEXT,    1'b1, 3'd2, 1'b1, 3'd1, 1'b1, 3'd0, 1'b0, 2'd0, 1'b0};
      4'd4:  w = '{OP_NEXT,    1'b1, 3'd3, 1'b1, 3'd2, 1'b1, 3'd1, 1'b0, 2'd0, 1'b0};
      4'd5:  w = '{OP_NEXT,    1'b1, 3'd4, 1'b1, 3'd3, 1'b1, 3'd2, 1'b0, 2'd0, 1'b0};
      4'd6:  w = '{OP_NEXT,    1'b1, 3'd5, 1'b1, 3'd4, 1'b1, 3'd3, 1'b0, 2'd0, 1'b0};
      4'd7:  w = '{OP_NEXT,    1'b1, 3'd6, 1'b1, 3'd5, 1'b1, 3'd4, 1'b0, 2'd0, 1'b0};
      4'd8:  w = '{OP_NEXT,    1'b1, 3'd7, 1'b1, 3'd6, 1'b1, 3'd5, 1'b0, 2'd0, 1'b0};
      4'd9:  w = '{OP_NEXT,    1'b0, 3'd0, 1'b1, 3'd7, 1'b1, 3'd6, 1'b0, 2'd0, 1'b0};
      4'd10: w = '{OP_NEXT,    1'b0, 3'd0, 1'b0, 3'd0, 1'b1, 3'd7, 1'b0, 2'd0, 1'b0};
      4'd11: w = '{OP_NEXT,    1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b1, 2'd0, 1'b1};
      4'd12: w = '{OP_NEXT,    1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b1, 2'd1, 1'b0};
      4'd13: w = '{OP_NEXT,    1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b1, 2'd2, 1'b0};
      4'd14: w = '{OP_NEXT,    1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b1, 2'd3, 1'b0};
      4'd15: w = '{OP_PUBLISH, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 2'd0, 1'b0};
      default: w = '{OP_WAIT_IN, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0, 1'b0, 2'd0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/qsfm_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
interface qsfm_in_if;
  logic                valid;
  logic                ready;
  qsfm_pkg::in_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface qsfm_out_if;
  logic                valid;
  logic                ready;
  qsfm_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface qsfm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [qsfm_pkg::IDX_W-1:0]            idx;
  logic [qsfm_pkg::EXTRA_W-1:0]          wdata;
  modport source(output valid, output idx, output wdata, input ready);
  modport sink(input valid, input idx, input wdata, output ready);
endinterface

// ----- hw/rtl/qsfm_seq.sv -----
// Microcode sequencer: step counter, control ROM and handshake control.
module qsfm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output qsfm_pkg::dp_ctrl_t ctrl_o
);

  logic [qsfm_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  qsfm_pkg::ucode_t            uc;
  logic                        accept;
  logic                        publish;

  assign uc      = qsfm_pkg::ucode(step_q);
  assign accept  = (uc.op == qsfm_pkg::OP_WAIT_IN) && in_valid_i;
  assign publish = (uc.op == qsfm_pkg::OP_PUBLISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (uc.op)
      qsfm_pkg::OP_WAIT_IN: step_d = accept ? step_q + 1'b1 : step_q;
      qsfm_pkg::OP_NEXT:    step_d = step_q + 1'b1;
      qsfm_pkg::OP_PUBLISH: step_d = publish ? '0 : step_q;
      default:              step_d = '0;
    endcase
  end

  always_comb begin
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = (uc.op == qsfm_pkg::OP_WAIT_IN);
  assign out_valid_o    = out_valid_q;
  assign ctrl_o.uc      = uc;
  assign ctrl_o.load    = accept;
  assign ctrl_o.publish = publish;

endmodule

// ----- hw/rtl/qsfm_dp.sv -----
// Datapath: gain registers, multipliers, accumulators, drive finish and tilt cutoff latch.
module qsfm_dp #(
  parameter int unsigned STATE_FRAC_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qsfm_pkg::dp_ctrl_t                  ctrl_i,
  input  logic                                cfg_we_i,
  input  logic [qsfm_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [qsfm_pkg::EXTRA_W-1:0]        cfg_wdata_i,
  input  qsfm_pkg::in_item_t                  in_data_i,
  output qsfm_pkg::out_item_t                 out_data_o
);

  localparam int unsigned FB_SHIFT = STATE_FRAC_BITS + 4;
  localparam int unsigned FF_SHIFT = 8;
  localparam logic [31:0] TILT_LIM = 32'((31415 * (1 << STATE_FRAC_BITS)) / 30000);

  localparam int unsigned FW = qsfm_pkg::FIELD_W;
  localparam int unsigned AW = qsfm_pkg::ACC_W;
  localparam int unsigned NM = qsfm_pkg::NMOTORS;

  // Configuration registers
  logic [FW-1:0]                        ref_gain_q, angle_gain_q, rate_gain_q, yaw_gain_q;
  logic signed [qsfm_pkg::EXTRA_W-1:0]  extra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_gain_q   <= qsfm_pkg::RST_REF_GAIN;
      angle_gain_q <= qsfm_pkg::RST_ANGLE_GAIN;
      rate_gain_q  <= qsfm_pkg::RST_RATE_GAIN;
      yaw_gain_q   <= qsfm_pkg::RST_YAW_RATE_GAIN;
      extra_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qsfm_pkg::REG_REF_GAIN:      ref_gain_q   <= cfg_wdata_i[FW-1:0];
        qsfm_pkg::REG_ANGLE_GAIN:    angle_gain_q <= cfg_wdata_i[FW-1:0];
        qsfm_pkg::REG_RATE_GAIN:     rate_gain_q  <= cfg_wdata_i[FW-1:0];
        qsfm_pkg::REG_YAW_RATE_GAIN: yaw_gain_q   <= cfg_wdata_i[FW-1:0];
        qsfm_pkg::REG_EXTRA_THRUST:  extra_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Request hold register
  qsfm_pkg::in_item_t req_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= in_data_i;
    end
  end

  // Stage one: state times gain
  logic signed [FW-1:0]             x_sel;
  logic [FW-1:0]                    g_sel;
  logic signed [qsfm_pkg::P1_W-1:0] p1_q;

  always_comb begin
    unique case (ctrl_i.uc.m1_term)
      qsfm_pkg::T_ROLL:      begin x_sel = req_q.roll_angle;   g_sel = angle_gain_q; end
      qsfm_pkg::T_PITCH:     begin x_sel = req_q.pitch_angle;  g_sel = angle_gain_q; end
      qsfm_pkg::T_ROLL_RATE: begin x_sel = req_q.roll_rate;    g_sel = rate_gain_q;  end
      qsfm_pkg::T_PITCH_RT:  begin x_sel = req_q.pitch_rate;   g_sel = rate_gain_q;  end
      qsfm_pkg::T_YAW_RATE:  begin x_sel = req_q.yaw_rate;     g_sel = yaw_gain_q;   end
      qsfm_pkg::T_REF_ROLL:  begin x_sel = req_q.ref_roll;     g_sel = ref_gain_q;   end
      qsfm_pkg::T_REF_PITCH: begin x_sel = req_q.ref_pitch;    g_sel = ref_gain_q;   end
      qsfm_pkg::T_REF_YAW:   begin x_sel = req_q.ref_yaw_rate; g_sel = ref_gain_q;   end
      default:               begin x_sel = '0;                 g_sel = '0;           end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uc.m1_en) begin
      p1_q <= qsfm_pkg::P1_W'(x_sel * $signed({1'b0, g_sel}));
    end
  end

  // Stage two: times folded constant
  logic signed [qsfm_pkg::P2_W-1:0]    p2_q;
  logic signed [qsfm_pkg::CONST_W-1:0] c_sel;

  assign c_sel = $signed(qsfm_pkg::TERM_CONST[ctrl_i.uc.m2_term]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uc.m2_en) begin
      p2_q <= qsfm_pkg::P2_W'(p1_q * c_sel);
    end
  end

  // Accumulate into feedback or feedforward sums with per-motor signs
  logic signed [AW-1:0] fb_q [NM];
  logic signed [AW-1:0] ff_q [NM];
  logic signed [AW-1:0] term;
  logic [NM-1:0]        sub;
  logic                 is_ff;

  assign term  = AW'(p2_q);
  assign sub   = qsfm_pkg::TERM_SUB[ctrl_i.uc.acc_term];
  assign is_ff = (ctrl_i.uc.acc_term >= qsfm_pkg::T_REF_ROLL);

  for (genvar k = 0; k < NM; k++) begin : g_acc
    always_ff @(posedge clk_i) begin
      if (ctrl_i.load) begin
        fb_q[k] <= '0;
        ff_q[k] <= '0;
      end else if (ctrl_i.uc.acc_en) begin
        if (is_ff) begin
          ff_q[k] <= sub[k] ? ff_q[k] - term : ff_q[k] + term;
        end else begin
          fb_q[k] <= sub[k] ? fb_q[k] - term : fb_q[k] + term;
        end
      end
    end
  end

  // Finish one motor: floor shifts, clamp, add thrust, saturate
  logic signed [AW:0]                u;
  logic signed [AW:0]                d;
  logic [16:0]                       dc;
  logic signed [qsfm_pkg::SUM_W-1:0] sum;
  logic [FW-1:0]                     drive;
  logic [FW-1:0]                     res_q [NM];

  always_comb begin
    u = (AW+1)'(fb_q[ctrl_i.uc.fin_motor] >>> FB_SHIFT)
      + (AW+1)'(ff_q[ctrl_i.uc.fin_motor] >>> FF_SHIFT);
    d = u >>> 16;
    if (d < 0) begin
      dc = '0;
    end else if (d > $signed((AW+1)'(qsfm_pkg::DRIVE_PRECLAMP))) begin
      dc = qsfm_pkg::DRIVE_PRECLAMP;
    end else begin
      dc = d[16:0];
    end
    sum = $signed(qsfm_pkg::SUM_W'(dc)) + $signed(qsfm_pkg::SUM_W'(req_q.thrust_cmd))
        + qsfm_pkg::SUM_W'(extra_q);
    if (sum < 0) begin
      drive = '0;
    end else if (sum > $signed(qsfm_pkg::SUM_W'(qsfm_pkg::DRIVE_MAX))) begin
      drive = qsfm_pkg::DRIVE_MAX;
    end else begin
      drive = sum[FW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uc.fin_en) begin
      res_q[ctrl_i.uc.fin_motor] <= drive;
    end
  end

  // Tilt cutoff latch
  logic [FW:0] roll_mag, pitch_mag;
  logic        over;
  logic        tripped_q;

  assign roll_mag  = req_q.roll_angle[FW-1]
                   ? (FW+1)'(-$signed({req_q.roll_angle[FW-1], req_q.roll_angle}))
                   : {1'b0, req_q.roll_angle};
  assign pitch_mag = req_q.pitch_angle[FW-1]
                   ? (FW+1)'(-$signed({req_q.pitch_angle[FW-1], req_q.pitch_angle}))
                   : {1'b0, req_q.pitch_angle};
  assign over = (32'(roll_mag) > TILT_LIM) || (32'(pitch_mag) > TILT_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tripped_q <= 1'b0;
    end else if (ctrl_i.uc.trip_en && over) begin
      tripped_q <= 1'b1;
    end
  end

  // Result register
  qsfm_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.publish) begin
      out_q.motor_one     <= tripped_q ? '0 : res_q[0];
      out_q.motor_two     <= tripped_q ? '0 : res_q[1];
      out_q.motor_three   <= tripped_q ? '0 : res_q[2];
      out_q.motor_four    <= tripped_q ? '0 : res_q[3];
      out_q.cutoff_active <= tripped_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hw/rtl/quadrotor_state_feedback_mixer_core.sv -----
// Top level of the quadrotor state-feedback motor mixer.
//
//   channel | dir | modport | carries
//   --------+-----+---------+--------------------------------------------
//   in_i    | in  | sink    | one control tick: attitude, rates, refs, thrust
//   res_o   | out | source  | four motor drives and the cutoff flag
//   cfg_i   | in  | sink    | register index and write data, always ready
//
// Each request is accepted, then its eight terms pass through the shared
// gain and constant multipliers (two register stages plus an accumulate step),
// the four motors are finished one after another, and the result is published.
// The result register lets the next request enter while a result waits.
// Reset clears the sequencer, the cutoff latch and restores the gain registers.
// A stalled result holds the sequencer at its publish step until taken.
module quadrotor_state_feedback_mixer_core #(
  parameter int unsigned STATE_FRAC_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qsfm_in_if.sink          in_i,
  qsfm_out_if.source       res_o,
  qsfm_cfg_if.sink         cfg_i
);

  qsfm_pkg::dp_ctrl_t ctrl;

  // Register writes land directly; the port never stalls.
  assign cfg_i.ready = 1'b1;

  // Step through the microcode and run the handshakes.
  qsfm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .ctrl_o      (ctrl)
  );

  // Hold the request, run the arithmetic and the cutoff latch.
  qsfm_dp #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.idx),
    .cfg_wdata_i (cfg_i.wdata),
    .in_data_i   (in_i.data),
    .out_data_o  (res_o.data)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the quadrotor state-feedback motor mixer core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qsfm_pkg::*;

  // Angle scaling used by the core instance.
  localparam int unsigned STATE_FRAC_BITS = 10;
  // Largest angle magnitude that stays at or below 60 degrees.
  localparam int TILT_EDGE = (31415 * (1 << STATE_FRAC_BITS)) / 30000;
  localparam int CYCLES_PER_TICK = 16;
  localparam longint RUN_LIMIT_NS = 5_000_000;
  localparam int PHASES = 8;
  localparam int TICKS_PER_PHASE = 175;
  localparam int TICKS_AFTER_TRIP = 40;
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = REG_EXTRA_THRUST + 3'd1;

  // Thrust-folded feedback and feedforward gains, scaled by 4096.
  localparam longint K_ROLL       = 6173195;
  localparam longint K_PITCH      = 6353793;
  localparam longint K_ROLL_RATE  = 19573989;
  localparam longint K_PITCH_RATE = 20157742;
  localparam longint K_YAW_RATE   = 31686876;
  localparam longint K_REF_ROLL   = 108249;
  localparam longint K_REF_PITCH  = 111433;
  localparam longint K_REF_YAW    = 553979;

  // One row of a scripted sequence: either a register write or a request.
  typedef struct {
    bit                 is_reg;
    logic [IDX_W-1:0]   idx;
    logic [EXTRA_W-1:0] wdata;
    in_item_t           tick;
    bit                 known;
    out_item_t          want;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  qsfm_in_if  in_ch();
  qsfm_out_if res_ch();
  qsfm_cfg_if cfg_ch();

  quadrotor_state_feedback_mixer_core #(
    .STATE_FRAC_BITS(STATE_FRAC_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  // Shadow copy of the register file and the cutoff latch.
  longint ref_gain_q;
  longint angle_gain_q;
  longint rate_gain_q;
  longint yaw_gain_q;
  longint extra_thrust_q;
  bit     tilt_latched;

  out_item_t   pending_drives[$];
  script_row_t script[$];
  int unsigned mismatch_cnt;
  int unsigned result_cnt;
  bit          feed_calm;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Kill a hung run; the bound is several times the slowest legal run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Turn one motor's feedback and feedforward sums into a saturated drive.
  function automatic logic [FIELD_W-1:0] drive_of(input longint fb, input longint ff,
                                                  input longint thrust);
    longint u;
    longint d;
    // Both sums carry extra fraction bits; drop them with floor rounding.
    u = (fb >>> (STATE_FRAC_BITS + 4)) + (ff >>> 8);
    d = u >>> 16;
    // Clamp the control part first, then add the thrust offsets and saturate.
    if (d < 0) d = 0;
    d = d + thrust + extra_thrust_q;
    if (d < 0) d = 0;
    if (d > longint'(DRIVE_MAX)) d = longint'(DRIVE_MAX);
    return d[FIELD_W-1:0];
  endfunction

  // Strictly above 60 degrees trips the latch.
  function automatic bit over_tilt(input longint angle);
    longint mag;
    mag = (angle < 0) ? -angle : angle;
    return mag * 30000 > 64'sd31415 * (64'sd1 << STATE_FRAC_BITS);
  endfunction

  // Compute the four drives for one request and advance the cutoff latch.
  function automatic out_item_t mix_drives(input in_item_t t);
    longint ra, pa, rr, pr, yr, fr, fp, fy, thr;
    logic [FIELD_W-1:0] drv [NMOTORS];
    out_item_t o;
    ra = longint'(t.roll_angle) * K_ROLL * angle_gain_q;
    pa = longint'(t.pitch_angle) * K_PITCH * angle_gain_q;
    rr = longint'(t.roll_rate) * K_ROLL_RATE * rate_gain_q;
    pr = longint'(t.pitch_rate) * K_PITCH_RATE * rate_gain_q;
    yr = longint'(t.yaw_rate) * K_YAW_RATE * yaw_gain_q;
    fr = longint'(t.ref_roll) * K_REF_ROLL * ref_gain_q;
    // The pitch reference enters with its sign flipped.
    fp = -longint'(t.ref_pitch) * K_REF_PITCH * ref_gain_q;
    fy = longint'(t.ref_yaw_rate) * K_REF_YAW * ref_gain_q;
    thr = longint'(t.thrust_cmd);
    drv[0] = drive_of(ra + pa + rr + pr + yr, -fr - fp - fy, thr);
    drv[1] = drive_of(ra - pa + rr - pr - yr, -fr + fp + fy, thr);
    drv[2] = drive_of(-ra - pa - rr - pr + yr, fr + fp - fy, thr);
    drv[3] = drive_of(-ra + pa - rr + pr - yr, fr - fp + fy, thr);
    // Both axes are checked; the latch applies from this request on.
    if (over_tilt(longint'(t.roll_angle)) || over_tilt(longint'(t.pitch_angle)))
      tilt_latched = 1'b1;
    o.motor_one     = tilt_latched ? '0 : drv[0];
    o.motor_two     = tilt_latched ? '0 : drv[1];
    o.motor_three   = tilt_latched ? '0 : drv[2];
    o.motor_four    = tilt_latched ? '0 : drv[3];
    o.cutoff_active = tilt_latched;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic in_item_t mk_tick(input int ra, input int pa, input int rr,
                                       input int pr, input int yr, input int fr,
                                       input int fp, input int fy, input int thr);
    in_item_t t;
    t.roll_angle   = ra[15:0];
    t.pitch_angle  = pa[15:0];
    t.roll_rate    = rr[15:0];
    t.pitch_rate   = pr[15:0];
    t.yaw_rate     = yr[15:0];
    t.ref_roll     = fr[15:0];
    t.ref_pitch    = fp[15:0];
    t.ref_yaw_rate = fy[15:0];
    t.thrust_cmd   = thr[15:0];
    return t;
  endfunction

  function automatic out_item_t mk_drives(input int m, input bit cut);
    out_item_t o;
    o.motor_one     = m[15:0];
    o.motor_two     = m[15:0];
    o.motor_three   = m[15:0];
    o.motor_four    = m[15:0];
    o.cutoff_active = cut;
    return o;
  endfunction

  function automatic void add_tick(input in_item_t t);
    script_row_t r;
    r = '{default: '0};
    r.tick = t;
    script.push_back(r);
  endfunction

  function automatic void add_known(input in_item_t t, input out_item_t want);
    script_row_t r;
    r = '{default: '0};
    r.tick  = t;
    r.known = 1'b1;
    r.want  = want;
    script.push_back(r);
  endfunction

  function automatic void add_reg(input logic [IDX_W-1:0] idx,
                                  input logic [EXTRA_W-1:0] val);
    script_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.wdata  = val;
    script.push_back(r);
  endfunction

  // Mix magnitudes so that drives land both inside and at the rails.
  function automatic logic [15:0] pick_s16();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 512)) - 256;
      1: v = int'($urandom_range(0, 8192)) - 4096;
      2: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v[15:0];
  endfunction

  // Keep the angle at or below the tilt limit so the latch stays open.
  function automatic logic [15:0] pick_level();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 128)) - 64;
      1: v = $urandom_range(0, 1) ? TILT_EDGE : -TILT_EDGE;
      default: v = int'($urandom_range(0, 2 * TILT_EDGE)) - TILT_EDGE;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_thrust();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 2048);
      1: v = $urandom_range(20000, 45000);
      2: v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  function automatic in_item_t draw_tick(input bit wild_tilt);
    in_item_t t;
    t.roll_angle   = wild_tilt ? pick_s16() : pick_level();
    t.pitch_angle  = wild_tilt ? pick_s16() : pick_level();
    t.roll_rate    = pick_s16();
    t.pitch_rate   = pick_s16();
    t.yaw_rate     = pick_s16();
    t.ref_roll     = pick_s16();
    t.ref_pitch    = pick_s16();
    t.ref_yaw_rate = pick_s16();
    t.thrust_cmd   = pick_thrust();
    return t;
  endfunction

  function automatic logic [15:0] pick_gain();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers and the result checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Drop the request valid and hold until every pending result has been taken.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  // Write one register with the core idle; leave valid high so a following
  // write in the same step does not fight a lowering of it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [EXTRA_W-1:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_REF_GAIN:      ref_gain_q     = longint'(val[15:0]);
      REG_ANGLE_GAIN:    angle_gain_q   = longint'(val[15:0]);
      REG_RATE_GAIN:     rate_gain_q    = longint'(val[15:0]);
      REG_YAW_RATE_GAIN: yaw_gain_q     = longint'(val[15:0]);
      REG_EXTRA_THRUST:  extra_thrust_q = longint'($signed(val));
      default: ;  // unused indexes are dropped by the core
    endcase
  endtask

  // Program the full register set, with a write to an unused index first.
  task automatic load_regs(input int rg, input int ag, input int rtg, input int yg,
                           input int extra);
    write_reg(REG_UNUSED_LO + IDX_W'($urandom_range(0, 2)), EXTRA_W'($urandom));
    write_reg(REG_REF_GAIN, EXTRA_W'(rg));
    write_reg(REG_ANGLE_GAIN, EXTRA_W'(ag));
    write_reg(REG_RATE_GAIN, EXTRA_W'(rtg));
    write_reg(REG_YAW_RATE_GAIN, EXTRA_W'(yg));
    write_reg(REG_EXTRA_THRUST, EXTRA_W'(extra));
  endtask

  // Offer one request after a random gap and queue its drives on acceptance.
  task automatic send_tick(input in_item_t t, input bit known, input out_item_t want);
    int unsigned gap;
    out_item_t pred;
    if ($urandom_range(0, 47) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 15);
    cfg_ch.valid <= 1'b0;
    // Lower valid only for a real gap, so back-to-back requests keep it high.
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    // Run the predictor even for typed rows so the latch stays in step.
    pred = mix_drives(t);
    pending_drives.push_back(known ? want : pred);
  endtask

  task automatic check_drives(input out_item_t got);
    out_item_t want;
    result_cnt++;
    if (pending_drives.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request pending", result_cnt));
    end else begin
      want = pending_drives.pop_front();
      if (got.motor_one !== want.motor_one)
        report_mismatch($sformatf("result %0d motor_one %0d, want %0d",
                                  result_cnt, got.motor_one, want.motor_one));
      if (got.motor_two !== want.motor_two)
        report_mismatch($sformatf("result %0d motor_two %0d, want %0d",
                                  result_cnt, got.motor_two, want.motor_two));
      if (got.motor_three !== want.motor_three)
        report_mismatch($sformatf("result %0d motor_three %0d, want %0d",
                                  result_cnt, got.motor_three, want.motor_three));
      if (got.motor_four !== want.motor_four)
        report_mismatch($sformatf("result %0d motor_four %0d, want %0d",
                                  result_cnt, got.motor_four, want.motor_four));
      if (got.cutoff_active !== want.cutoff_active)
        report_mismatch($sformatf("result %0d cutoff_active %0b, want %0b",
                                  result_cnt, got.cutoff_active, want.cutoff_active));
    end
  endtask

  // Result side: stall a random number of cycles per result, with calm
  // stretches where ready stays high; check each result as it is taken.
  initial begin : result_sink
    int unsigned stall;
    bit calm;
    calm = 1'b0;
    res_ch.ready = 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if ($urandom_range(0, 47) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      check_drives(res_ch.data);
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    script_row_t row;
    out_item_t   none;
    none = '0;
    mismatch_cnt = 0;
    result_cnt = 0;
    feed_calm = 1'b0;
    // Drive every input to a known value before the first edge.
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx   = '0;
    cfg_ch.wdata = '0;
    rst_ni       = 1'b0;
    ref_gain_q     = longint'(RST_REF_GAIN);
    angle_gain_q   = longint'(RST_ANGLE_GAIN);
    rate_gain_q    = longint'(RST_RATE_GAIN);
    yaw_gain_q     = longint'(RST_YAW_RATE_GAIN);
    extra_thrust_q = 0;
    tilt_latched   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset gains: rails, field extremes, the tilt
    // edge on both axes without tripping, and register corner cases.
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0), mk_drives(0, 1'b0));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 65535), mk_drives(65500, 1'b0));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 65500), mk_drives(65500, 1'b0));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 12345), mk_drives(12345, 1'b0));
    add_tick(mk_tick(TILT_EDGE, 0, 0, 0, 0, 0, 0, 0, 30000));
    add_tick(mk_tick(-TILT_EDGE, 0, 0, 0, 0, 0, 0, 0, 30000));
    add_tick(mk_tick(0, TILT_EDGE, 0, 0, 0, 0, 0, 0, 30000));
    add_tick(mk_tick(0, -TILT_EDGE, 0, 0, 0, 0, 0, 0, 30000));
    add_tick(mk_tick(0, 0, 32767, -32768, 32767, 0, 0, 0, 20000));
    add_tick(mk_tick(0, 0, -32768, 32767, -32768, 0, 0, 0, 20000));
    add_tick(mk_tick(0, 0, 0, 0, 0, 32767, -32768, 32767, 30000));
    add_tick(mk_tick(0, 0, 0, 0, 0, -32768, 32767, -32768, 30000));
    add_tick(mk_tick(-1, -1, -1, -1, -1, -1, -1, -1, 65535));
    add_tick(mk_tick(37, -59, 211, -143, 77, 25, -40, 12, 32000));
    // Unused index must leave the gains alone.
    add_reg(REG_UNUSED_LO + 3'd2, 17'h15a5a);
    add_tick(mk_tick(37, -59, 211, -143, 77, 25, -40, 12, 32000));
    // Zero gains and an offset of -65535: the sum drops to zero or below.
    add_reg(REG_REF_GAIN, '0);
    add_reg(REG_ANGLE_GAIN, '0);
    add_reg(REG_RATE_GAIN, '0);
    add_reg(REG_YAW_RATE_GAIN, '0);
    add_reg(REG_EXTRA_THRUST, EXTRA_W'(-65535));
    add_known(mk_tick(500, -500, 900, 900, -900, 1000, 1000, 1000, 0), mk_drives(0, 1'b0));
    add_known(mk_tick(500, -500, 900, 900, -900, 1000, 1000, 1000, 65535),
              mk_drives(0, 1'b0));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 1000), mk_drives(0, 1'b0));
    add_reg(REG_EXTRA_THRUST, EXTRA_W'(65535));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0), mk_drives(65500, 1'b0));
    add_reg(REG_EXTRA_THRUST, EXTRA_W'(100));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 200), mk_drives(300, 1'b0));

    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) begin
        write_reg(row.idx, row.wdata);
      end else begin
        send_tick(row.tick, row.known, row.want);
      end
    end

    // Random phases: each one drains the core, reprograms every register
    // and then streams requests that keep the latch open.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_regs(RST_REF_GAIN, RST_ANGLE_GAIN, RST_RATE_GAIN, RST_YAW_RATE_GAIN, 0);
        1: load_regs(65535, 65535, 65535, 65535, -65535);
        2: load_regs(0, 0, 0, 0, 65535);
        3: load_regs(1, 1, 1, 1, -1);
        default: load_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                           int'($urandom_range(0, 131070)) - 65535);
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) send_tick(draw_tick(1'b0), 1'b0, none);
    end

    // Closing section: one request at the tilt edge, then trip the latch on
    // the pitch axis and confirm it holds through new requests and writes.
    script.delete();
    add_tick(mk_tick(TILT_EDGE, -TILT_EDGE, 100, -100, 50, 20, -20, 10, 30000));
    add_known(mk_tick(0, TILT_EDGE + 1, 0, 0, 0, 0, 0, 0, 30000), mk_drives(0, 1'b1));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 40000), mk_drives(0, 1'b1));
    add_reg(REG_EXTRA_THRUST, EXTRA_W'(65535));
    add_known(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 65535), mk_drives(0, 1'b1));
    add_known(mk_tick(-32768, 32767, 0, 0, 0, 0, 0, 0, 65535), mk_drives(0, 1'b1));
    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) begin
        write_reg(row.idx, row.wdata);
      end else begin
        send_tick(row.tick, row.known, row.want);
      end
    end
    for (int n = 0; n < TICKS_AFTER_TRIP; n++) send_tick(draw_tick(1'b1), 1'b0, none);

    // Drain, then give a stray extra result time to show up.
    wait_idle();
    repeat (4 * CYCLES_PER_TICK) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- quadrotor_state_feedback_mixer_core.f -----
hw/rtl/qsfm_pkg.sv
hw/rtl/qsfm_if.sv
hw/rtl/qsfm_seq.sv
hw/rtl/qsfm_dp.sv
hw/rtl/quadrotor_state_feedback_mixer_core.sv
sim/tb_top.sv
